// File: hw/rtl/sha1h_pkg.sv
package sha1h_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    // Where the controller goes once a compression has been folded into the chain.
    typedef enum logic [1:0] {
        TAIL_IDLE,
        TAIL_PAD,
        TAIL_LEN,
        TAIL_EMIT
    } tail_t;

    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [2:0]  LAST_WORD  = 3'd4;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  POS_LONG   = 6'd56;
    localparam logic [5:0]  POS_LAST   = 6'd63;

    typedef struct packed {
        logic       load_byte;
        logic       round;
        logic [6:0] rnd_idx;
        logic       add_chain;
        logic       pad;
        logic       len;
        logic       clear;
        logic [2:0] emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_long;
    } dp_stat_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            default: val = 32'hC3D2E1F0;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] val;
        if (rnd < 7'd20)
            val = 32'h5A827999;
        else if (rnd < 7'd40)
            val = 32'h6ED9EBA1;
        else if (rnd < 7'd60)
            val = 32'h8F1BBCDC;
        else
            val = 32'hCA62C1D6;
        return val;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] val;
        if (rnd < 7'd20)
            val = (b & c) | (~b & d);
        else if (rnd >= 7'd40 && rnd < 7'd60)
            val = (b & c) | (b & d) | (c & d);
        else
            val = b ^ c ^ d;
        return val;
    endfunction

endpackage

// File: hw/rtl/sha1h_dp.sv
module sha1h_dp
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_byte,
    output dp_stat_t    stat,
    output logic [31:0] digest_word
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [60:0] total_reg;

    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [1:0]  lane;
    logic [4:0]  lane_sh;
    logic [63:0] bit_len;
    logic [31:0] data_word;
    logic [31:0] pad_word;
    logic [31:0] sched_word;
    logic [31:0] temp;

    assign pos     = total_reg[5:0];
    assign widx    = pos[5:2];
    assign lane    = pos[1:0];
    assign lane_sh = {~lane, 3'b000};
    assign bit_len = {total_reg, 3'b000};

    assign stat.pos_last = (pos == POS_LAST);
    assign stat.pos_long = (pos >= POS_LONG);

    // A byte at the start of a word clears the rest of that word.
    assign data_word = ((lane == 2'd0) ? 32'd0 : w_reg[widx]) | (32'(data_byte) << lane_sh);
    assign pad_word  = ((lane == 2'd0) ? 32'd0 : w_reg[widx]) | (32'(PAD_BYTE) << lane_sh);

    assign sched_word = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    assign temp = {a_reg[26:0], a_reg[31:27]}
                + round_f(cmd.rnd_idx, b_reg, c_reg, d_reg)
                + e_reg + w_reg[0] + round_k(cmd.rnd_idx);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (cmd.load_byte)
        begin
            w_next[widx] = data_word;
        end
        else if (cmd.round)
        begin
            // The schedule runs as a shift line; the round word sits at the head.
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = {sched_word[30:0], sched_word[31]};
        end
        else if (cmd.pad)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > widx)
                    w_next[i] = 32'd0;
            end
            w_next[widx] = pad_word;
            if (!stat.pos_long)
            begin
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
            end
        end
        else if (cmd.len)
        begin
            for (int i = 0; i < 14; i++)
            begin
                w_next[i] = 32'd0;
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        if (cmd.round)
        begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
            total_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= iv_word(3'(i));
                end
                total_reg <= '0;
            end
            else
            begin
                if (cmd.add_chain)
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                if (cmd.load_byte)
                begin
                    total_reg <= total_reg + 61'd1;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.emit_idx)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            default: digest_word = h_reg[4];
        endcase
    end

endmodule

// File: hw/rtl/sha1h_ctrl.sv
module sha1h_ctrl
    import sha1h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       no_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] word_index,
    output logic       final_word,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    tail_t      tail_reg, tail_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;
    logic       out_done;

    assign accept   = in_valid && in_ready;
    assign out_done = out_valid && out_ready && (idx_reg == LAST_WORD);

    always_comb
    begin
        state_next = state_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!no_byte && stat.pos_last)
                    begin
                        state_next = ST_ROUND;
                        tail_next  = is_last ? TAIL_PAD : TAIL_IDLE;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                unique case (tail_reg)
                    TAIL_IDLE: state_next = ST_IDLE;
                    TAIL_PAD:  state_next = ST_PAD;
                    TAIL_LEN:  state_next = ST_LEN;
                    TAIL_EMIT: state_next = ST_EMIT;
                endcase
            end
            ST_PAD:
            begin
                // When the marker byte lands past byte 55 the length needs a block of its own.
                state_next = ST_ROUND;
                tail_next  = stat.pos_long ? TAIL_LEN : TAIL_EMIT;
            end
            ST_LEN:
            begin
                state_next = ST_ROUND;
                tail_next  = TAIL_EMIT;
            end
            ST_EMIT:
            begin
                if (out_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rnd_next = (state_reg == ST_ROUND) ? rnd_reg + 7'd1 : 7'd0;
        idx_next = idx_reg;
        if (out_valid && out_ready)
            idx_next = (idx_reg == LAST_WORD) ? 3'd0 : idx_reg + 3'd1;
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        out_valid     = (state_reg == ST_EMIT);
        word_index    = idx_reg;
        final_word    = (idx_reg == LAST_WORD);
        cmd.load_byte = accept && !no_byte;
        cmd.round     = (state_reg == ST_ROUND);
        cmd.rnd_idx   = rnd_reg;
        cmd.add_chain = (state_reg == ST_FINAL);
        cmd.pad       = (state_reg == ST_PAD);
        cmd.len       = (state_reg == ST_LEN);
        cmd.clear     = out_done;
        cmd.emit_idx  = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tail_reg  <= TAIL_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == LAST_ROUND) |=> (state_reg == ST_FINAL))
        else $error("compression did not end after the last round");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_word) |=> (in_ready && word_index == 3'd0))
        else $error("block not idle after the last digest word");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= LAST_ROUND))
        else $error("round counter ran past the last round");

endmodule

// File: hw/rtl/sha1_byte_stream_hasher.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | data_byte, no_byte, is_last
// out     | output    | out_valid / out_ready | digest_word, word_index, final_word
//
// A byte item that does not fill the block leaves the input ready for the next item.
// The 64th byte of a block starts a compression: 80 rounds of one shared round unit, one chain add.
// A last item adds padding and a compression, plus a length block and compression when the
// final block holds 56+ bytes; five digest words follow, one per cycle with out_ready high.
// Reset is asynchronous on rst_n; the chain comes up at the initial vector.
// Input is not taken during compression or while digest words wait; out_ready low holds a word.
module sha1_byte_stream_hasher
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha1h_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .no_byte    (no_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .final_word (final_word),
        .stat       (stat),
        .cmd        (cmd)
    );

    sha1h_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .stat        (stat),
        .digest_word (digest_word)
    );

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       nb;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  idx;
        logic        fin;
    } digest_beat_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int IDLE_PERCENT   = 34;
    localparam int CALM_FIRST     = 150;
    localparam int CALM_END       = 230;
    localparam int RANDOM_ITEMS   = 360;
    localparam int MSG_ROOM       = 30;
    localparam logic [7:0] PAD_MARK = 8'h80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        no_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    in_word_t     pending_words[$];
    digest_beat_t digest_queue[$];

    // Running hash state of the predictor.
    logic [31:0] chain_h[5];
    logic [31:0] msg_words[16];
    logic [60:0] msg_len;

    int errors = 0;
    int words_taken = 0;
    int beats_checked = 0;
    int digests_done = 0;
    int stall_cycles = 0;

    sha1_byte_stream_hasher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .no_byte(no_byte),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .digest_word(digest_word),
        .word_index(word_index),
        .final_word(final_word)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void hash_restart();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        for (int i = 0; i < 16; i++)
            msg_words[i] = 32'h0;
        msg_len = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = msg_words[i];
        for (int i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Big-endian byte placement; the first byte of a word clears the rest of it.
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] v);
        int wi;
        int sh;
        wi = pos[5:2];
        sh = (3 - pos[1:0]) * 8;
        if (pos[1:0] == 2'd0)
            msg_words[wi] = 32'h0;
        msg_words[wi] |= {24'h0, v} << sh;
    endfunction

    function automatic void hash_word(input in_word_t wd);
        logic [5:0]  pos;
        logic [63:0] bits;
        digest_beat_t beat;
        if (!wd.nb)
        begin
            pos = msg_len[5:0];
            place_byte(pos, wd.data);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63)
                compress_block();
        end
        if (wd.last)
        begin
            pos = msg_len[5:0];
            place_byte(pos, PAD_MARK);
            for (int wi = pos[5:2] + 1; wi < 16; wi++)
                msg_words[wi] = 32'h0;
            // No room for the length field: one extra padding block.
            if (pos >= 6'd56)
            begin
                compress_block();
                for (int wi = 0; wi < 16; wi++)
                    msg_words[wi] = 32'h0;
            end
            bits = {msg_len, 3'b000};
            msg_words[14] = bits[63:32];
            msg_words[15] = bits[31:0];
            compress_block();
            for (int j = 0; j < 5; j++)
            begin
                beat.value = chain_h[j];
                beat.idx   = 3'(j);
                beat.fin   = (j == 4);
                digest_queue.push_back(beat);
            end
            hash_restart();
        end
    endfunction

    function automatic bit take_break();
        if (words_taken >= CALM_FIRST && words_taken < CALM_END)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    function automatic void push_word(input logic [7:0] data, input logic nb, input logic last);
        in_word_t wd;
        wd.data = data;
        wd.nb   = nb;
        wd.last = last;
        pending_words.push_back(wd);
    endfunction

    // One message of random bytes; it closes either on its last byte or with a
    // separate word that carries no byte. Stray empty words are mixed in.
    function automatic void add_message(input int len);
        bit close_on_byte;
        close_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            push_word(8'($urandom_range(0, 255)), 1'b0, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte)
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endfunction

    // Driver: presents the next pending word and predicts each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                hash_word('{data: data_byte, nb: no_byte, last: is_last});
                words_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && !take_break())
                begin
                    in_valid  <= 1'b1;
                    data_byte <= pending_words[0].data;
                    no_byte   <= pending_words[0].nb;
                    is_last   <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted digest word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h at index %0d", digest_word, word_index);
                    errors++;
                end
                else
                begin
                    if (digest_word !== digest_queue[0].value)
                    begin
                        $error("digest_word: expected %h, got %h",
                               digest_queue[0].value, digest_word);
                        errors++;
                    end
                    if (word_index !== digest_queue[0].idx)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               digest_queue[0].idx, word_index);
                        errors++;
                    end
                    if (final_word !== digest_queue[0].fin)
                    begin
                        $error("final_word: expected %0b, got %0b",
                               digest_queue[0].fin, final_word);
                        errors++;
                    end
                    if (digest_queue[0].fin)
                        digests_done++;
                    void'(digest_queue.pop_front());
                    beats_checked++;
                end
            end
            out_ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        hash_restart();

        // Empty message, then an ignored empty word ahead of another empty message.
        push_word(8'h00, 1'b1, 1'b1);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'h00, 1'b1, 1'b1);
        // "abc", closed on its last byte.
        push_word(8'h61, 1'b0, 1'b0);
        push_word(8'h62, 1'b0, 1'b0);
        push_word(8'h63, 1'b0, 1'b1);
        // Byte extremes, closed by a word without a byte.
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'hFF, 1'b1, 1'b1);
        // Single byte message.
        push_word(8'hFF, 1'b0, 1'b1);
        // Ignored word in the middle of a message.
        push_word(8'h55, 1'b0, 1'b0);
        push_word(8'hAA, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);

        // Lengths on both sides of the padding and block boundaries first.
        add_message(55);
        add_message(56);
        add_message(63);
        add_message(64);
        // Stop a little short of the target so the last message lands near it.
        while (pending_words.size() < RANDOM_ITEMS - MSG_ROOM)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_message($urandom_range(0, 6));
                6, 7, 8:          add_message($urandom_range(52, 66));
                default:          add_message($urandom_range(0, 130));
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_valid)
            @(posedge clk);
        while (digest_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (digest_queue.size() > 0)
        begin
            $error("%0d digest words never arrived", digest_queue.size());
            errors++;
        end
        $display("Hashed %0d input words into %0d digests (%0d digest words checked),",
                 words_taken, digests_done, beats_checked);
        $display("covering empty messages, ignored words and lengths at the padding edges.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
